/* src/swmv_pkg.sv */
// shared types and constants of the sliding window mean and variance block
`timescale 1ns / 1ps

package swmv_pkg;

  // fixed field widths
  localparam int SAMPLE_BITS = 16;
  localparam int FRAC_BITS   = 16;
  localparam int MEAN_W      = 32;
  localparam int VAR_W       = 48;
  localparam int COUNT_W     = 7;

  // input transaction modes
  localparam logic MODE_PUSH  = 1'b0;
  localparam logic MODE_CLEAR = 1'b1;

  // sequencer states
  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_READ = 7'b0000010,
    S_ACC  = 7'b0000100,
    S_MUL  = 7'b0001000,
    S_MDIV = 7'b0010000,
    S_VDIV = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  // ring store access strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } ring_ctl_t;

  // divider status
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

/* src/swmv_ifs.sv */
// valid/ready channel interfaces for samples and statistics
`timescale 1ns / 1ps

interface swmv_in_if;
  logic                                   valid;
  logic                                   ready;
  logic                                   mode;
  logic signed [swmv_pkg::SAMPLE_BITS-1:0] sample;

  modport source (output valid, output mode, output sample, input ready);
  modport sink   (input valid, input mode, input sample, output ready);
endinterface

interface swmv_out_if;
  logic                               valid;
  logic                               ready;
  logic signed [swmv_pkg::MEAN_W-1:0]  mean;
  logic        [swmv_pkg::VAR_W-1:0]   variance;
  logic        [swmv_pkg::COUNT_W-1:0] count;

  modport source (output valid, output mean, output variance, output count, input ready);
  modport sink   (input valid, input mean, input variance, input count, output ready);
endinterface

/* src/swmv_ring.sv */
// sample ring store, one write and one registered read port
`timescale 1ns / 1ps

module swmv_ring #(
  parameter int DEPTH = 64,
  parameter int AW    = 6,
  parameter int DW    = 16
) (
  input  logic                clk,
  input  swmv_pkg::ring_ctl_t ctl,
  input  logic [AW-1:0]       rd_addr,
  input  logic [AW-1:0]       wr_addr,
  input  logic [DW-1:0]       wr_data,
  output logic [DW-1:0]       rd_data
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* src/swmv_div.sv */
// unsigned restoring divider, one quotient bit per cycle
`timescale 1ns / 1ps

module swmv_div #(
  parameter int DVD_W = 61,
  parameter int DVS_W = 14
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_W-1:0]    dividend,
  input  logic [DVS_W-1:0]    divisor,
  output swmv_pkg::div_stat_t stat,
  output logic [DVD_W-1:0]    quotient
);

  localparam int CNT_W = $clog2(DVD_W + 1);

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [DVS_W:0]   rem_r, rem_nxt;
  logic [DVS_W-1:0] dvs_r, dvs_nxt;
  logic [DVD_W-1:0] dvd_r, dvd_nxt;
  logic [DVD_W-1:0] quo_r, quo_nxt;
  logic [DVS_W:0]   rem_sh;
  logic             fits;

  // one shift and trial subtract
  assign rem_sh = {rem_r[DVS_W-1:0], dvd_r[DVD_W-1]};
  assign fits   = rem_sh >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DVD_W);
      rem_nxt  = '0;
      dvs_nxt  = divisor;
      dvd_nxt  = dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? (rem_sh - {1'b0, dvs_r}) : rem_sh;
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quotient  = quo_r;

endmodule

/* src/sliding_window_mean_variance.sv */
// Sliding window mean and unbiased variance of signed 16-bit samples.
// The last WINDOW samples sit in a ring memory; running sum and sum of squares are
// updated per push, and mean (signed Q16.16) and variance (unsigned Q32.16, saturating)
// are computed exactly, truncated toward zero. One transaction is handled at a time.
// A push runs a read-modify-write through the read, accumulate and multiply states,
// then two passes through a shared divider that produces one quotient bit per cycle,
// with dividend width DVD_W = 2*clog2(WINDOW+1) + 47; when the count is below two
// or the numerator is not positive the second pass is skipped.
// A clear goes straight to the done state. A finished result waits in the output register
// while the next transaction is accepted.
`timescale 1ns / 1ps

module sliding_window_mean_variance #(
  parameter int WINDOW = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  swmv_in_if.sink     in_ch,
  swmv_out_if.source  out_ch
);

  localparam int SB    = swmv_pkg::SAMPLE_BITS;
  localparam int FB    = swmv_pkg::FRAC_BITS;
  localparam int MW    = swmv_pkg::MEAN_W;
  localparam int VW    = swmv_pkg::VAR_W;
  localparam int CW    = $clog2(WINDOW + 1);
  localparam int AW    = $clog2(WINDOW);
  localparam int SUM_W = SB + CW;
  localparam int SQ_W  = 2 * SB - 1 + CW;
  localparam int PW    = CW + SQ_W;
  localparam int DVD_W = PW + FB;
  localparam int DVS_W = 2 * CW;

  swmv_pkg::state_t state_r, state_nxt;

  logic [AW-1:0]           oldest_r, oldest_nxt;
  logic [AW-1:0]           next_r, next_nxt;
  logic [CW-1:0]           count_r, count_nxt;
  logic signed [SUM_W-1:0] sum_r, sum_nxt;
  logic [SQ_W-1:0]         sq_r, sq_nxt;
  logic signed [SB-1:0]    x_r, x_nxt;
  logic signed [SB-1:0]    old_r, old_nxt;
  logic [2*SB-1:0]         xsq_r, xsq_nxt;
  logic [2*SB-1:0]         oldsq_r, oldsq_nxt;
  logic [PW-1:0]           nq_r, nq_nxt;
  logic [PW-1:0]           ss_r, ss_nxt;
  logic                    neg_r, neg_nxt;
  logic signed [MW-1:0]    mean_r, mean_nxt;
  logic [VW-1:0]           var_r, var_nxt;

  logic                    out_valid_r, out_valid_nxt;
  logic signed [MW-1:0]    out_mean_r, out_mean_nxt;
  logic [VW-1:0]           out_var_r, out_var_nxt;
  logic [CW-1:0]           out_count_r, out_count_nxt;

  logic                    in_fire;
  logic                    full;
  logic signed [2*SB-1:0]  xsq_s, oldsq_s;
  logic signed [SB-1:0]    old_sel;
  logic [SUM_W-1:0]        mag_w;
  logic [2*SUM_W-1:0]      ss_w;
  logic [PW-1:0]           nq_w;
  logic [DVS_W-1:0]        pair_w;

  swmv_pkg::ring_ctl_t     ring_ctl;
  logic [SB-1:0]           ring_rdata;

  logic                    div_start;
  logic [DVD_W-1:0]        div_dvd;
  logic [DVS_W-1:0]        div_dvs;
  swmv_pkg::div_stat_t     div_stat;
  logic [DVD_W-1:0]        div_quo;

  swmv_ring #(
    .DEPTH (WINDOW),
    .AW    (AW),
    .DW    (SB)
  ) u_ring (
    .clk     (clk),
    .ctl     (ring_ctl),
    .rd_addr (oldest_r),
    .wr_addr (next_r),
    .wr_data (x_r),
    .rd_data (ring_rdata)
  );

  swmv_div #(
    .DVD_W (DVD_W),
    .DVS_W (DVS_W)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .stat     (div_stat),
    .quotient (div_quo)
  );

  // handshake
  assign in_ch.ready = (state_r == swmv_pkg::S_IDLE);
  assign in_fire     = in_ch.valid && in_ch.ready;

  // arithmetic helpers
  assign full    = (count_r == CW'(WINDOW));
  assign old_sel = full ? signed'(ring_rdata) : '0;
  assign xsq_s   = x_r * x_r;
  assign oldsq_s = old_sel * old_sel;
  assign mag_w   = sum_r[SUM_W-1] ? unsigned'(-sum_r) : unsigned'(sum_r);
  assign ss_w    = mag_w * mag_w;
  assign nq_w    = PW'(count_r) * PW'(sq_r);
  assign pair_w  = DVS_W'(count_r) * DVS_W'(count_r - 1'b1);

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    oldest_nxt    = oldest_r;
    next_nxt      = next_r;
    count_nxt     = count_r;
    sum_nxt       = sum_r;
    sq_nxt        = sq_r;
    x_nxt         = x_r;
    old_nxt       = old_r;
    xsq_nxt       = xsq_r;
    oldsq_nxt     = oldsq_r;
    nq_nxt        = nq_r;
    ss_nxt        = ss_r;
    neg_nxt       = neg_r;
    mean_nxt      = mean_r;
    var_nxt       = var_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_mean_nxt  = out_mean_r;
    out_var_nxt   = out_var_r;
    out_count_nxt = out_count_r;
    ring_ctl      = '0;
    div_start     = 1'b0;
    div_dvd       = DVD_W'({mag_w, FB'(0)});
    div_dvs       = DVS_W'(count_r);

    case (state_r)
      swmv_pkg::S_IDLE: begin
        if (in_fire) begin
          x_nxt = in_ch.sample;
          if (in_ch.mode == swmv_pkg::MODE_CLEAR) begin
            oldest_nxt = '0;
            next_nxt   = '0;
            count_nxt  = '0;
            sum_nxt    = '0;
            sq_nxt     = '0;
            mean_nxt   = '0;
            var_nxt    = '0;
            state_nxt  = swmv_pkg::S_DONE;
          end else begin
            ring_ctl.rd_en = 1'b1;
            state_nxt      = swmv_pkg::S_READ;
          end
        end
      end
      // leaving sample and squares
      swmv_pkg::S_READ: begin
        old_nxt   = old_sel;
        xsq_nxt   = unsigned'(xsq_s);
        oldsq_nxt = unsigned'(oldsq_s);
        state_nxt = swmv_pkg::S_ACC;
      end
      // update sums, write new sample, advance slots
      swmv_pkg::S_ACC: begin
        sum_nxt        = sum_r - SUM_W'(old_r) + SUM_W'(x_r);
        sq_nxt         = sq_r - SQ_W'(oldsq_r) + SQ_W'(xsq_r);
        ring_ctl.wr_en = 1'b1;
        next_nxt       = (next_r == AW'(WINDOW - 1)) ? '0 : next_r + 1'b1;
        if (full) begin
          oldest_nxt = (oldest_r == AW'(WINDOW - 1)) ? '0 : oldest_r + 1'b1;
        end else begin
          count_nxt = count_r + 1'b1;
        end
        state_nxt = swmv_pkg::S_MUL;
      end
      // products for the variance numerator, launch mean division
      swmv_pkg::S_MUL: begin
        nq_nxt    = nq_w;
        ss_nxt    = ss_w[PW-1:0];
        neg_nxt   = sum_r[SUM_W-1];
        div_start = 1'b1;
        state_nxt = swmv_pkg::S_MDIV;
      end
      swmv_pkg::S_MDIV: begin
        if (div_stat.done) begin
          mean_nxt = neg_r ? -signed'(div_quo[MW-1:0]) : signed'(div_quo[MW-1:0]);
          if ((count_r >= CW'(2)) && (nq_r > ss_r)) begin
            div_start = 1'b1;
            div_dvd   = {nq_r - ss_r, FB'(0)};
            div_dvs   = pair_w;
            state_nxt = swmv_pkg::S_VDIV;
          end else begin
            var_nxt   = '0;
            state_nxt = swmv_pkg::S_DONE;
          end
        end
      end
      swmv_pkg::S_VDIV: begin
        if (div_stat.done) begin
          var_nxt   = (div_quo[DVD_W-1:VW] != '0) ? '1 : div_quo[VW-1:0];
          state_nxt = swmv_pkg::S_DONE;
        end
      end
      // hand the result to the output register
      swmv_pkg::S_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_mean_nxt  = mean_r;
          out_var_nxt   = var_r;
          out_count_nxt = count_r;
          state_nxt     = swmv_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = swmv_pkg::S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swmv_pkg::S_IDLE;
      oldest_r    <= '0;
      next_r      <= '0;
      count_r     <= '0;
      sum_r       <= '0;
      sq_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      oldest_r    <= oldest_nxt;
      next_r      <= next_nxt;
      count_r     <= count_nxt;
      sum_r       <= sum_nxt;
      sq_r        <= sq_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    x_r         <= x_nxt;
    old_r       <= old_nxt;
    xsq_r       <= xsq_nxt;
    oldsq_r     <= oldsq_nxt;
    nq_r        <= nq_nxt;
    ss_r        <= ss_nxt;
    neg_r       <= neg_nxt;
    mean_r      <= mean_nxt;
    var_r       <= var_nxt;
    out_mean_r  <= out_mean_nxt;
    out_var_r   <= out_var_nxt;
    out_count_r <= out_count_nxt;
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.mean     = out_mean_r;
  assign out_ch.variance = out_var_r;
  assign out_ch.count    = swmv_pkg::COUNT_W'(out_count_r);

endmodule
